### rtl/core/wbsa_pkg.sv
package wbsa_pkg;

    localparam logic [1:0] ACT_MATRIX  = 2'd0;
    localparam logic [1:0] ACT_VECTOR  = 2'd1;
    localparam logic [1:0] ACT_COUNTS  = 2'd2;
    localparam logic [1:0] ACT_ENCRYPT = 2'd3;

    localparam int WORD_W      = 64;
    localparam int BIT_IDX_W   = 7;
    localparam int ENTRY_W     = 2 * BIT_IDX_W;
    localparam int LAYER_SEL_W = 6;
    localparam int SLOT_W      = 11;
    localparam int MCOUNT_IN_W = 12;
    localparam int VCOUNT_IN_W = 8;

    typedef struct packed {
        logic load;
        logic m_apply;
        logic v_apply;
        logic commit;
        logic add;
        logic out_load;
    } dp_cmd_t;

endpackage

### rtl/core/wbsa_tables.sv
module wbsa_tables #(
    parameter int ROUND_COUNT  = 34,
    parameter int MATRIX_SLOTS = 2048,
    parameter int VECTOR_SLOTS = 128,
    localparam int LAYERS  = ROUND_COUNT + 1,
    localparam int LAYER_W = $clog2(LAYERS),
    localparam int MIDX_W  = (MATRIX_SLOTS > 1) ? $clog2(MATRIX_SLOTS) : 1,
    localparam int VIDX_W  = (VECTOR_SLOTS > 1) ? $clog2(VECTOR_SLOTS) : 1,
    localparam int MCNT_W  = $clog2(MATRIX_SLOTS + 1),
    localparam int VCNT_W  = $clog2(VECTOR_SLOTS + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [1:0]                          action,
    input  logic [wbsa_pkg::LAYER_SEL_W-1:0]    layer_sel,
    input  logic [wbsa_pkg::SLOT_W-1:0]         slot,
    input  logic [wbsa_pkg::BIT_IDX_W-1:0]      row_bit,
    input  logic [wbsa_pkg::BIT_IDX_W-1:0]      col_bit,
    input  logic [wbsa_pkg::MCOUNT_IN_W-1:0]    matrix_count,
    input  logic [wbsa_pkg::VCOUNT_IN_W-1:0]    vector_count,
    input  logic [LAYER_W-1:0]                  rd_layer,
    input  logic [LAYER_W-1:0]                  cnt_layer,
    input  logic [MIDX_W-1:0]                   m_rd_idx,
    input  logic [VIDX_W-1:0]                   v_rd_idx,
    input  logic                                m_rd,
    input  logic                                v_rd,
    output logic [wbsa_pkg::ENTRY_W-1:0]        m_entry,
    output logic [wbsa_pkg::BIT_IDX_W-1:0]      v_entry,
    output logic [MCNT_W-1:0]                   m_count,
    output logic [VCNT_W-1:0]                   v_count
);
    import wbsa_pkg::*;

    localparam int MDEPTH  = LAYERS * MATRIX_SLOTS;
    localparam int VDEPTH  = LAYERS * VECTOR_SLOTS;
    localparam int MADDR_W = $clog2(MDEPTH);
    localparam int VADDR_W = $clog2(VDEPTH);

    logic [ENTRY_W-1:0]   mtab [MDEPTH];
    logic [BIT_IDX_W-1:0] vtab [VDEPTH];
    logic [ENTRY_W-1:0]   m_entry_reg;
    logic [BIT_IDX_W-1:0] v_entry_reg;
    logic [MCNT_W-1:0]    mcount_mem [LAYERS];
    logic [VCNT_W-1:0]    vcount_mem [LAYERS];
    logic [MCNT_W-1:0]    mcount_rd_reg;
    logic [VCNT_W-1:0]    vcount_rd_reg;
    logic [LAYERS-1:0]    cnt_set_reg;
    logic                 cnt_set_rd_reg;

    logic                 layer_ok;
    logic                 m_we;
    logic                 v_we;
    logic                 c_we;
    logic [MADDR_W-1:0]   m_waddr;
    logic [MADDR_W-1:0]   m_raddr;
    logic [VADDR_W-1:0]   v_waddr;
    logic [VADDR_W-1:0]   v_raddr;
    logic [MCNT_W-1:0]    mcount_sat;
    logic [VCNT_W-1:0]    vcount_sat;

    always_comb
    begin
        layer_ok   = int'(layer_sel) <= ROUND_COUNT;
        m_we       = wr_en && (action == ACT_MATRIX) && layer_ok
                     && (int'(slot) < MATRIX_SLOTS);
        v_we       = wr_en && (action == ACT_VECTOR) && layer_ok
                     && (int'(slot) < VECTOR_SLOTS);
        c_we       = wr_en && (action == ACT_COUNTS) && layer_ok;
        m_waddr    = MADDR_W'(int'(layer_sel) * MATRIX_SLOTS + int'(slot));
        v_waddr    = VADDR_W'(int'(layer_sel) * VECTOR_SLOTS + int'(slot));
        m_raddr    = MADDR_W'(int'(rd_layer) * MATRIX_SLOTS + int'(m_rd_idx));
        v_raddr    = VADDR_W'(int'(rd_layer) * VECTOR_SLOTS + int'(v_rd_idx));
        mcount_sat = (int'(matrix_count) > MATRIX_SLOTS) ? MCNT_W'(MATRIX_SLOTS)
                                                         : MCNT_W'(matrix_count);
        vcount_sat = (int'(vector_count) > VECTOR_SLOTS) ? VCNT_W'(VECTOR_SLOTS)
                                                         : VCNT_W'(vector_count);
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mtab[m_waddr] <= {row_bit, col_bit};
        end
        if (m_rd)
        begin
            m_entry_reg <= mtab[m_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vtab[v_waddr] <= row_bit;
        end
        if (v_rd)
        begin
            v_entry_reg <= vtab[v_raddr];
        end
    end

    // counts of the layer the engine works on next cycle
    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            mcount_mem[LAYER_W'(layer_sel)] <= mcount_sat;
            vcount_mem[LAYER_W'(layer_sel)] <= vcount_sat;
        end
        mcount_rd_reg <= mcount_mem[cnt_layer];
        vcount_rd_reg <= vcount_mem[cnt_layer];
    end

    // a layer whose counts were never set reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_set_reg    <= '0;
            cnt_set_rd_reg <= 1'b0;
        end
        else
        begin
            if (c_we)
            begin
                cnt_set_reg[LAYER_W'(layer_sel)] <= 1'b1;
            end
            cnt_set_rd_reg <= cnt_set_reg[cnt_layer];
        end
    end

    assign m_entry = m_entry_reg;
    assign v_entry = v_entry_reg;
    assign m_count = cnt_set_rd_reg ? mcount_rd_reg : '0;
    assign v_count = cnt_set_rd_reg ? vcount_rd_reg : '0;

endmodule

### rtl/core/wbsa_datapath.sv
module wbsa_datapath #(
    parameter int HALF_WIDTH = 64
) (
    input  logic                              clk,
    input  wbsa_pkg::dp_cmd_t                 cmd,
    input  logic [wbsa_pkg::WORD_W-1:0]       plain_x,
    input  logic [wbsa_pkg::WORD_W-1:0]       plain_y,
    input  logic [wbsa_pkg::ENTRY_W-1:0]      m_entry,
    input  logic [wbsa_pkg::BIT_IDX_W-1:0]    v_entry,
    output logic [wbsa_pkg::WORD_W-1:0]       cipher_x,
    output logic [wbsa_pkg::WORD_W-1:0]       cipher_y
);
    import wbsa_pkg::*;

    localparam int BLK_W = 2 * HALF_WIDTH;
    localparam int POS_W = $clog2(BLK_W);

    logic [BLK_W-1:0]      w_reg;
    logic [BLK_W-1:0]      w_next;
    logic [BLK_W-1:0]      acc_reg;
    logic [BLK_W-1:0]      acc_next;
    logic [HALF_WIDTH-1:0] cx_reg;
    logic [HALF_WIDTH-1:0] cy_reg;

    logic [BIT_IDX_W-1:0]  m_row;
    logic [BIT_IDX_W-1:0]  m_col;
    logic                  m_hit;
    logic                  v_hit;
    logic [POS_W-1:0]      flip_pos;
    logic [HALF_WIDTH-1:0] sum_x;

    always_comb
    begin
        m_row    = m_entry[ENTRY_W-1:BIT_IDX_W];
        m_col    = m_entry[BIT_IDX_W-1:0];
        m_hit    = cmd.m_apply && (int'(m_row) < BLK_W) && (int'(m_col) < BLK_W)
                   && w_reg[m_col[POS_W-1:0]];
        v_hit    = cmd.v_apply && (int'(v_entry) < BLK_W);
        flip_pos = cmd.m_apply ? m_row[POS_W-1:0] : v_entry[POS_W-1:0];
        sum_x    = acc_reg[HALF_WIDTH-1:0] + acc_reg[BLK_W-1:HALF_WIDTH];
        w_next   = w_reg;
        acc_next = acc_reg;
        priority if (cmd.load)
        begin
            w_next   = {plain_y[HALF_WIDTH-1:0], plain_x[HALF_WIDTH-1:0]};
            acc_next = '0;
        end
        else if (cmd.commit)
        begin
            w_next   = {acc_reg[BLK_W-1:HALF_WIDTH],
                        cmd.add ? sum_x : acc_reg[HALF_WIDTH-1:0]};
            acc_next = '0;
        end
        else if (m_hit || v_hit)
        begin
            acc_next[flip_pos] = ~acc_reg[flip_pos];
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        acc_reg <= acc_next;
        if (cmd.out_load)
        begin
            cx_reg <= w_reg[HALF_WIDTH-1:0];
            cy_reg <= w_reg[BLK_W-1:HALF_WIDTH];
        end
    end

    assign cipher_x = WORD_W'(cx_reg);
    assign cipher_y = WORD_W'(cy_reg);

endmodule

### rtl/core/wbsa_ctrl.sv
module wbsa_ctrl #(
    parameter int ROUND_COUNT  = 34,
    parameter int MATRIX_SLOTS = 2048,
    parameter int VECTOR_SLOTS = 128,
    localparam int LAYERS  = ROUND_COUNT + 1,
    localparam int LAYER_W = $clog2(LAYERS),
    localparam int MIDX_W  = (MATRIX_SLOTS > 1) ? $clog2(MATRIX_SLOTS) : 1,
    localparam int VIDX_W  = (VECTOR_SLOTS > 1) ? $clog2(VECTOR_SLOTS) : 1,
    localparam int MCNT_W  = $clog2(MATRIX_SLOTS + 1),
    localparam int VCNT_W  = $clog2(VECTOR_SLOTS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            action,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    input  logic [MCNT_W-1:0]     m_count,
    input  logic [VCNT_W-1:0]     v_count,
    output logic [LAYER_W-1:0]    rd_layer,
    output logic [LAYER_W-1:0]    cnt_layer,
    output logic [MIDX_W-1:0]     m_rd_idx,
    output logic [VIDX_W-1:0]     v_rd_idx,
    output logic                  m_rd,
    output logic                  v_rd,
    output wbsa_pkg::dp_cmd_t     cmd
);
    import wbsa_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAT    = 3'd1;
    localparam logic [2:0] S_VEC    = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [LAYER_W-1:0] layer_reg;
    logic [LAYER_W-1:0] layer_next;
    logic [MCNT_W-1:0]  midx_reg;
    logic [MCNT_W-1:0]  midx_next;
    logic [VCNT_W-1:0]  vidx_reg;
    logic [VCNT_W-1:0]  vidx_next;
    logic               m_apply_reg;
    logic               v_apply_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               start;
    logic               last_layer;

    always_comb
    begin
        start          = in_valid && in_ready && (action == ACT_ENCRYPT);
        last_layer     = layer_reg == LAYER_W'(ROUND_COUNT);
        state_next     = state_reg;
        layer_next     = layer_reg;
        midx_next      = midx_reg;
        vidx_next      = vidx_reg;
        m_rd           = 1'b0;
        v_rd           = 1'b0;
        cmd            = '0;
        cmd.m_apply    = m_apply_reg;
        cmd.v_apply    = v_apply_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    layer_next = '0;
                    midx_next  = '0;
                    vidx_next  = '0;
                    state_next = S_MAT;
                end
            end
            S_MAT:
            begin
                if (midx_reg < m_count)
                begin
                    m_rd      = 1'b1;
                    midx_next = midx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_VEC;
                end
            end
            S_VEC:
            begin
                if (vidx_reg < v_count)
                begin
                    v_rd      = 1'b1;
                    vidx_next = vidx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                cmd.add    = !last_layer;
                if (last_layer)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    layer_next = layer_reg + 1'b1;
                    midx_next  = '0;
                    vidx_next  = '0;
                    state_next = S_MAT;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            layer_reg     <= '0;
            midx_reg      <= '0;
            vidx_reg      <= '0;
            m_apply_reg   <= 1'b0;
            v_apply_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            layer_reg     <= layer_next;
            midx_reg      <= midx_next;
            vidx_reg      <= vidx_next;
            m_apply_reg   <= m_rd;
            v_apply_reg   <= v_rd;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign rd_layer  = layer_reg;
    assign cnt_layer = layer_next;
    assign m_rd_idx  = midx_reg[MIDX_W-1:0];
    assign v_rd_idx  = vidx_reg[VIDX_W-1:0];

endmodule

### rtl/core/white_box_speck_sparse_affine_top.sv
// White-box block encryption over ROUND_COUNT+1 sparse affine layers. A word with action
// write-matrix, write-vector or set-counts updates the layer tables. An encrypt word walks
// every layer: it reads the matrix entries, then the vector entries, then commits. The
// layer tables sit in memories with one registered read per cycle, and the engine reads
// one matrix or vector entry per cycle. Table words are taken whenever no encryption is
// running, also while a finished ciphertext waits at the output. Table entries below a
// layer's count must be written before an encryption reads them.
module white_box_speck_sparse_affine_top #(
    parameter int ROUND_COUNT  = 34,
    parameter int HALF_WIDTH   = 64,
    parameter int MATRIX_SLOTS = 2048,
    parameter int VECTOR_SLOTS = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          action,
    input  logic [wbsa_pkg::LAYER_SEL_W-1:0]    layer_sel,
    input  logic [wbsa_pkg::SLOT_W-1:0]         slot,
    input  logic [wbsa_pkg::BIT_IDX_W-1:0]      row_bit,
    input  logic [wbsa_pkg::BIT_IDX_W-1:0]      col_bit,
    input  logic [wbsa_pkg::MCOUNT_IN_W-1:0]    matrix_count,
    input  logic [wbsa_pkg::VCOUNT_IN_W-1:0]    vector_count,
    input  logic [wbsa_pkg::WORD_W-1:0]         plain_x,
    input  logic [wbsa_pkg::WORD_W-1:0]         plain_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [wbsa_pkg::WORD_W-1:0]         cipher_x,
    output logic [wbsa_pkg::WORD_W-1:0]         cipher_y
);
    import wbsa_pkg::*;

    localparam int LAYER_W = $clog2(ROUND_COUNT + 1);
    localparam int MIDX_W  = (MATRIX_SLOTS > 1) ? $clog2(MATRIX_SLOTS) : 1;
    localparam int VIDX_W  = (VECTOR_SLOTS > 1) ? $clog2(VECTOR_SLOTS) : 1;
    localparam int MCNT_W  = $clog2(MATRIX_SLOTS + 1);
    localparam int VCNT_W  = $clog2(VECTOR_SLOTS + 1);

    logic                 wr_en;
    logic [LAYER_W-1:0]   rd_layer;
    logic [LAYER_W-1:0]   cnt_layer;
    logic [MIDX_W-1:0]    m_rd_idx;
    logic [VIDX_W-1:0]    v_rd_idx;
    logic                 m_rd;
    logic                 v_rd;
    logic [ENTRY_W-1:0]   m_entry;
    logic [BIT_IDX_W-1:0] v_entry;
    logic [MCNT_W-1:0]    m_count;
    logic [VCNT_W-1:0]    v_count;
    dp_cmd_t              cmd;

    assign wr_en = in_valid && in_ready && (action != ACT_ENCRYPT);

    wbsa_tables #(
        .ROUND_COUNT  (ROUND_COUNT),
        .MATRIX_SLOTS (MATRIX_SLOTS),
        .VECTOR_SLOTS (VECTOR_SLOTS)
    ) u_tables (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .action       (action),
        .layer_sel    (layer_sel),
        .slot         (slot),
        .row_bit      (row_bit),
        .col_bit      (col_bit),
        .matrix_count (matrix_count),
        .vector_count (vector_count),
        .rd_layer     (rd_layer),
        .cnt_layer    (cnt_layer),
        .m_rd_idx     (m_rd_idx),
        .v_rd_idx     (v_rd_idx),
        .m_rd         (m_rd),
        .v_rd         (v_rd),
        .m_entry      (m_entry),
        .v_entry      (v_entry),
        .m_count      (m_count),
        .v_count      (v_count)
    );

    wbsa_datapath #(
        .HALF_WIDTH (HALF_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .plain_x  (plain_x),
        .plain_y  (plain_y),
        .m_entry  (m_entry),
        .v_entry  (v_entry),
        .cipher_x (cipher_x),
        .cipher_y (cipher_y)
    );

    wbsa_ctrl #(
        .ROUND_COUNT  (ROUND_COUNT),
        .MATRIX_SLOTS (MATRIX_SLOTS),
        .VECTOR_SLOTS (VECTOR_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .m_count   (m_count),
        .v_count   (v_count),
        .rd_layer  (rd_layer),
        .cnt_layer (cnt_layer),
        .m_rd_idx  (m_rd_idx),
        .v_rd_idx  (v_rd_idx),
        .m_rd      (m_rd),
        .v_rd      (v_rd),
        .cmd       (cmd)
    );

    // at most one table entry lands in the accumulator per cycle
    a_one_apply: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.m_apply && cmd.v_apply))
        else $error("matrix and vector entries applied together");

    // no read in flight once the engine is ready for a new word
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!cmd.m_apply && !cmd.v_apply && !m_rd && !v_rd))
        else $error("table read pending while idle");

    // a new result appears only after the engine loaded the output register
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("output valid without a result load");

endmodule

### tb/cipher_checker.sv
module cipher_checker #(
    parameter int ROUNDS = 34,
    parameter int MSLOTS = 2048,
    parameter int VSLOTS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [5:0]  layer_sel,
    input  logic [10:0] slot,
    input  logic [6:0]  row_bit,
    input  logic [6:0]  col_bit,
    input  logic [11:0] matrix_count,
    input  logic [7:0]  vector_count,
    input  logic [63:0] plain_x,
    input  logic [63:0] plain_y,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] cipher_x,
    input  logic [63:0] cipher_y,
    output int          mismatches,
    output int          owed
);
    import wbsa_pkg::*;

    localparam int LAYERS = ROUNDS + 1;

    typedef struct packed {
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] x;
    } cipher_t;

    logic [ENTRY_W-1:0]   mtx_entry [LAYERS*MSLOTS];
    logic [BIT_IDX_W-1:0] vec_entry [LAYERS*VSLOTS];
    int unsigned          mtx_len [LAYERS];
    int unsigned          vec_len [LAYERS];
    cipher_t              ciphers_due [$];
    int                   miss;

    function automatic cipher_t encrypt_block(input logic [63:0] px, input logic [63:0] py);
        logic [127:0]       blk;
        logic [127:0]       acc;
        logic [ENTRY_W-1:0] e;
        int                 k;
        int                 i;
        blk = {py, px};
        for (k = 0; k < LAYERS; k++)
        begin
            acc = '0;
            for (i = 0; i < mtx_len[k]; i++)
            begin
                e = mtx_entry[k*MSLOTS + i];
                if (blk[e[6:0]])
                    acc[e[13:7]] = ~acc[e[13:7]];
            end
            for (i = 0; i < vec_len[k]; i++)
                acc[vec_entry[k*VSLOTS + i]] = ~acc[vec_entry[k*VSLOTS + i]];
            // every layer but the last adds y into x
            if (k < ROUNDS)
                acc[63:0] = acc[63:0] + acc[127:64];
            blk = acc;
        end
        return cipher_t'(blk);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        cipher_t got;
        cipher_t want;
        int      k;
        if (!rst_n)
        begin
            for (k = 0; k < LAYERS; k++)
            begin
                mtx_len[k] = 0;
                vec_len[k] = 0;
            end
            ciphers_due.delete();
            miss = 0;
            mismatches <= 0;
            owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {cipher_y, cipher_x};
                if (ciphers_due.size() == 0)
                begin
                    if (miss < 10)
                        $display("unexpected cipher word x=%h y=%h", got.x, got.y);
                    miss++;
                end
                else
                begin
                    want = ciphers_due.pop_front();
                    if (got.x !== want.x || got.y !== want.y)
                    begin
                        if (miss < 10)
                            $display("cipher word wrong: x exp %h got %h, y exp %h got %h",
                                     want.x, got.x, want.y, got.y);
                        miss++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (action)
                    ACT_MATRIX:
                        if (layer_sel < LAYERS && slot < MSLOTS)
                            mtx_entry[int'(layer_sel)*MSLOTS + int'(slot)] = {row_bit, col_bit};
                    ACT_VECTOR:
                        if (layer_sel < LAYERS && slot < VSLOTS)
                            vec_entry[int'(layer_sel)*VSLOTS + int'(slot)] = row_bit;
                    ACT_COUNTS:
                        if (layer_sel < LAYERS)
                        begin
                            mtx_len[layer_sel] = (matrix_count > MSLOTS) ? MSLOTS : matrix_count;
                            vec_len[layer_sel] = (vector_count > VSLOTS) ? VSLOTS : vector_count;
                        end
                    ACT_ENCRYPT:
                        ciphers_due.push_back(encrypt_block(plain_x, plain_y));
                endcase
            end
            mismatches <= miss;
            owed <= ciphers_due.size();
        end
    end

endmodule

### tb/white_box_speck_sparse_affine_top_test.sv
module white_box_speck_sparse_affine_top_test;
    import wbsa_pkg::*;

    localparam int ROUNDS = 34;
    localparam int LAYERS = ROUNDS + 1;
    localparam int MSLOTS = 2048;
    localparam int VSLOTS = 128;
    localparam int LIMIT  = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [5:0]  layer_sel;
    logic [10:0] slot;
    logic [6:0]  row_bit;
    logic [6:0]  col_bit;
    logic [11:0] matrix_count;
    logic [7:0]  vector_count;
    logic [63:0] plain_x;
    logic [63:0] plain_y;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] cipher_x;
    logic [63:0] cipher_y;
    int          mismatches;
    int          owed;
    int          cycles = 0;
    bit          idle_on = 1'b1;

    // which table entries hold data, and how many leading ones per layer
    bit mtx_done [LAYERS*MSLOTS];
    bit vec_done [LAYERS*VSLOTS];
    int mtx_prefix [LAYERS];
    int vec_prefix [LAYERS];

    white_box_speck_sparse_affine_top #(
        .ROUND_COUNT  (ROUNDS),
        .HALF_WIDTH   (64),
        .MATRIX_SLOTS (MSLOTS),
        .VECTOR_SLOTS (VSLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .layer_sel    (layer_sel),
        .slot         (slot),
        .row_bit      (row_bit),
        .col_bit      (col_bit),
        .matrix_count (matrix_count),
        .vector_count (vector_count),
        .plain_x      (plain_x),
        .plain_y      (plain_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cipher_x     (cipher_x),
        .cipher_y     (cipher_y)
    );

    cipher_checker #(
        .ROUNDS (ROUNDS),
        .MSLOTS (MSLOTS),
        .VSLOTS (VSLOTS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .layer_sel    (layer_sel),
        .slot         (slot),
        .row_bit      (row_bit),
        .col_bit      (col_bit),
        .matrix_count (matrix_count),
        .vector_count (vector_count),
        .plain_x      (plain_x),
        .plain_y      (plain_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cipher_x     (cipher_x),
        .cipher_y     (cipher_y),
        .mismatches   (mismatches),
        .owed         (owed)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] pick_plain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int at_most(int a, int b);
        return (a < b) ? a : b;
    endfunction

    task automatic send_word(logic [1:0] act, logic [5:0] lay, logic [10:0] slt,
                             logic [6:0] rb, logic [6:0] cb, logic [11:0] mc,
                             logic [7:0] vc, logic [63:0] px, logic [63:0] py);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        repeat (gap) @(negedge clk) in_valid = 1'b0;
        @(negedge clk);
        in_valid     = 1'b1;
        action       = act;
        layer_sel    = lay;
        slot         = slt;
        row_bit      = rb;
        col_bit      = cb;
        matrix_count = mc;
        vector_count = vc;
        plain_x      = px;
        plain_y      = py;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic put_matrix(int lay, int slt, int rb, int cb);
        send_word(ACT_MATRIX, 6'(lay), 11'(slt), 7'(rb), 7'(cb),
                  12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                  pick_plain(), pick_plain());
        if (lay < LAYERS)
        begin
            mtx_done[lay*MSLOTS + slt] = 1'b1;
            while (mtx_prefix[lay] < MSLOTS && mtx_done[lay*MSLOTS + mtx_prefix[lay]])
                mtx_prefix[lay]++;
        end
    endtask

    task automatic put_vector(int lay, int slt, int rb);
        send_word(ACT_VECTOR, 6'(lay), 11'(slt), 7'(rb), 7'($urandom_range(0, 127)),
                  12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                  pick_plain(), pick_plain());
        if (lay < LAYERS && slt < VSLOTS)
        begin
            vec_done[lay*VSLOTS + slt] = 1'b1;
            while (vec_prefix[lay] < VSLOTS && vec_done[lay*VSLOTS + vec_prefix[lay]])
                vec_prefix[lay]++;
        end
    endtask

    task automatic put_counts(int lay, int mc, int vc);
        send_word(ACT_COUNTS, 6'(lay), 11'($urandom_range(0, 2047)),
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  12'(mc), 8'(vc), pick_plain(), pick_plain());
    endtask

    task automatic put_encrypt(logic [63:0] px, logic [63:0] py);
        send_word(ACT_ENCRYPT, 6'($urandom_range(0, 63)), 11'($urandom_range(0, 2047)),
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)), px, py);
    endtask

    // receiver: random back-pressure, plus one long hold-off to fill the block
    initial
    begin : receiver
        int gap;
        int taken;
        taken = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken == 12)
                repeat (2000) @(negedge clk) out_ready = 1'b0;
            gap = idle_on ? $urandom_range(0, 14) : 0;
            repeat (gap) @(negedge clk) out_ready = 1'b0;
            @(negedge clk) out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int n;
        int pick;
        int lay;
        int slt;
        int i;
        in_valid     = 1'b0;
        action       = ACT_MATRIX;
        layer_sel    = '0;
        slot         = '0;
        row_bit      = '0;
        col_bit      = '0;
        matrix_count = '0;
        vector_count = '0;
        plain_x      = '0;
        plain_y      = '0;
        rst_n        = 1'b0;
        for (i = 0; i < LAYERS; i++)
        begin
            mtx_prefix[i] = 0;
            vec_prefix[i] = 0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // empty tables
        put_encrypt('0, '0);
        put_encrypt('1, '1);

        // corner bit positions in the first and the final layer
        put_matrix(0, 0, 127, 0);
        put_matrix(0, 1, 0, 127);
        put_matrix(0, 2, 64, 63);
        put_vector(0, 0, 127);
        put_vector(0, 1, 0);
        put_matrix(ROUNDS, 0, 0, 0);
        put_matrix(ROUNDS, 1, 127, 127);
        put_matrix(ROUNDS, 2, 63, 64);
        put_vector(ROUNDS, 0, 64);
        put_vector(ROUNDS, VSLOTS - 1, 33);

        // out-of-range layer or slot, all dropped
        put_matrix(63, MSLOTS - 1, 127, 127);
        put_vector(40, 5, 1);
        put_vector(0, 2047, 9);
        put_counts(LAYERS, 4095, 255);

        put_counts(0, 3, 2);
        put_counts(ROUNDS, 3, 1);
        put_encrypt('1, 64'd1);

        put_encrypt('0, '0);
        put_encrypt('1, '1);
        put_encrypt('1, '0);
        put_encrypt('0, '1);
        put_encrypt(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);

        n = 0;
        while (n < 75)
        begin
            if (n % 20 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            lay = $urandom_range(0, ROUNDS);
            if (pick < 40)
            begin
                put_encrypt(pick_plain(), pick_plain());
                n++;
            end
            else if (pick < 62)
            begin
                if ($urandom_range(0, 19) == 0)
                    put_matrix($urandom_range(LAYERS, 63), $urandom_range(0, 2047),
                               $urandom_range(0, 127), $urandom_range(0, 127));
                else
                begin
                    if ($urandom_range(0, 9) == 0 || mtx_prefix[lay] == MSLOTS)
                        slt = $urandom_range(0, MSLOTS - 1);
                    else
                        slt = mtx_prefix[lay];
                    put_matrix(lay, slt, $urandom_range(0, 127), $urandom_range(0, 127));
                    n++;
                end
            end
            else if (pick < 77)
            begin
                if ($urandom_range(0, 9) == 0 || vec_prefix[lay] == VSLOTS)
                begin
                    slt = $urandom_range(0, 2047);
                    if ($urandom_range(0, 4) == 0)
                        lay = $urandom_range(LAYERS, 63);
                    put_vector(lay, slt, $urandom_range(0, 127));
                    if (lay < LAYERS && slt < VSLOTS)
                        n++;
                end
                else
                begin
                    put_vector(lay, vec_prefix[lay], $urandom_range(0, 127));
                    n++;
                end
            end
            else
            begin
                if ($urandom_range(0, 6) == 0)
                    put_counts($urandom_range(LAYERS, 63), $urandom_range(0, 4095),
                               $urandom_range(0, 255));
                else
                begin
                    put_counts(lay, $urandom_range(0, at_most(mtx_prefix[lay], 16)),
                               $urandom_range(0, at_most(vec_prefix[lay], 8)));
                    n++;
                end
            end
        end

        @(negedge clk) in_valid = 1'b0;
        while (owed != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### white_box_speck_sparse_affine_top.f
rtl/core/wbsa_pkg.sv
rtl/core/wbsa_tables.sv
rtl/core/wbsa_datapath.sv
rtl/core/wbsa_ctrl.sv
rtl/core/white_box_speck_sparse_affine_top.sv
tb/cipher_checker.sv
tb/white_box_speck_sparse_affine_top_test.sv
